FILE: hdl/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg
// Shared widths and codes for the chained hash set core.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int KEY_W   = 31;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 9;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 7'd64;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_REM_MISS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd4;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd5;
    localparam logic [STAT_W-1:0] ST_POOL_FULL = 3'd6;

endpackage

FILE: hdl/chs_mod.sv
// ----------------------------------------------------------------------------
// chs_mod
// Bit-serial restoring modulo: one key bit per cycle, one compare/subtract.
// ----------------------------------------------------------------------------
module chs_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [chs_pkg::KEY_W-1:0]    i_dividend,
    input  logic [chs_pkg::CFG_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [chs_pkg::CFG_W-1:0]    o_rem
);
    localparam int KW = chs_pkg::KEY_W;
    localparam int CW = chs_pkg::CFG_W;
    localparam int NW = $clog2(KW + 1);

    logic          r_busy, n_busy;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [KW-1:0] r_q, n_q;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_div;
    logic          r_done, n_done;
    logic [CW:0]   w_trial;

    assign w_trial = {r_rem, r_q[KW-1]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(KW);
            n_q    = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = CW'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = CW'(w_trial);
            end
            n_q   = {r_q[KW-2:0], 1'b0};
            n_cnt = r_cnt - NW'(1);
            if (r_cnt == NW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/chained_hash_set_core.sv
// ----------------------------------------------------------------------------
// chained_hash_set_core
// Set of non-negative keys in a hash table with separate chaining.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser = operation (0 insert, 1 remove,
//   2 search, 3 acts as search), tdata = key. m_axis returns one result
//   per request: tdata = status, element count. The cfg channel writes
//   bucket_count (0 acts as 1, values above BUCKETS act as BUCKETS); write
//   it only while no request is in flight.
// Sequence: the bit-serial modulo (one step per key bit, then a done flag),
//   a read of the bucket head, a fetch and compare per chain node visited
//   plus a check when the walk runs off the chain end, then the link updates
//   and the load of the result into the output register. The next request
//   can be taken as soon as that result is loaded. The modulo unit and the
//   chain walk dominate the time per request; one request at a time.
// Reset: a sweep over max(BUCKETS, NODES) entries nulls the bucket heads and
//   chains the free list; s_axis_tready stays low meanwhile.
// Stall: the result sits in an output register; a new request is taken
//   while it waits, but the next result waits until the register frees.
// ----------------------------------------------------------------------------
module chained_hash_set_core #(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] key
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] status, [11:3] element_total
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // [6:0] bucket_count
);
    localparam int KW  = chs_pkg::KEY_W;
    localparam int CW  = chs_pkg::CFG_W;
    localparam int SW  = chs_pkg::STAT_W;
    localparam int TW  = chs_pkg::TOTAL_W;
    localparam int OW  = chs_pkg::OP_W;
    localparam int NW  = $clog2(NODES + 1);
    localparam int AW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SWN = (NODES > BUCKETS) ? NODES : BUCKETS;
    localparam int XW  = $clog2(SWN + 1);
    localparam logic [NW-1:0] NULL_LINK = NW'(NODES);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DIV, S_HEAD, S_HEAD_WT, S_WALK, S_CMP,
        S_DECIDE, S_INS_RD, S_INS_WR, S_REM1, S_REM2, S_DONE
    } t_state;

    t_state          r_state;
    logic [XW-1:0]   r_sw;
    logic [CW-1:0]   r_bc;
    logic [OW-1:0]   r_op;
    logic [KW-1:0]   r_key;
    logic [BW-1:0]   r_bucket;
    logic [NW-1:0]   r_cur, r_prev, r_steps, r_hit, r_next, r_headv;
    logic [NW-1:0]   r_free, r_count;
    logic            r_found;
    logic [SW-1:0]   r_stat, r_res_stat;
    logic            r_ovalid;
    logic [TW-1:0]   r_total;

    // memories
    logic [NW-1:0]   bucket_head [BUCKETS];
    logic [KW-1:0]   node_key    [NODES];
    logic [NW-1:0]   node_link   [NODES];
    logic [NW-1:0]   r_head_q, r_link_q;
    logic [KW-1:0]   r_key_q;

    logic            w_head_we, w_key_we, w_link_we;
    logic [BW-1:0]   w_head_wa;
    logic [NW-1:0]   w_head_wd, w_link_wd;
    logic [AW-1:0]   w_link_wa, w_link_ra, w_key_wa;

    logic            w_div_start, w_div_done;
    logic [CW-1:0]   w_rem, w_mod;
    logic            w_in_xfer;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_div_start   = w_in_xfer;

    always_comb begin
        if (r_bc == '0) begin
            w_mod = CW'(1);
        end else if (32'(r_bc) > 32'(BUCKETS)) begin
            w_mod = CW'(BUCKETS);
        end else begin
            w_mod = r_bc;
        end
    end

    chs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (s_axis_tdata[KW-1:0]),
        .i_divisor  (w_mod),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // memory port control
    always_comb begin
        w_head_we = 1'b0;
        w_head_wa = r_bucket;
        w_head_wd = NULL_LINK;
        w_key_we  = 1'b0;
        w_key_wa  = r_free[AW-1:0];
        w_link_we = 1'b0;
        w_link_wa = r_free[AW-1:0];
        w_link_wd = r_headv;
        w_link_ra = (r_state == S_INS_RD) ? r_free[AW-1:0] : r_cur[AW-1:0];
        unique case (r_state)
            S_SWEEP: begin
                w_head_we = (32'(r_sw) < 32'(BUCKETS));
                w_head_wa = r_sw[BW-1:0];
                w_link_we = (32'(r_sw) < 32'(NODES));
                w_link_wa = r_sw[AW-1:0];
                w_link_wd = NW'(r_sw) + NW'(1);
            end
            S_INS_WR: begin
                w_head_we = 1'b1;
                w_head_wd = r_free;
                w_key_we  = 1'b1;
                w_link_we = 1'b1;
            end
            S_REM1: begin
                if (r_prev == NULL_LINK) begin
                    w_head_we = 1'b1;
                    w_head_wd = r_next;
                end else begin
                    w_link_we = 1'b1;
                    w_link_wa = r_prev[AW-1:0];
                    w_link_wd = r_next;
                end
            end
            S_REM2: begin
                w_link_we = 1'b1;
                w_link_wa = r_hit[AW-1:0];
                w_link_wd = r_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            bucket_head[w_head_wa] <= w_head_wd;
        end
        r_head_q <= bucket_head[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            node_key[w_key_wa] <= r_key;
        end
        r_key_q <= node_key[r_cur[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            node_link[w_link_wa] <= w_link_wd;
        end
        r_link_q <= node_link[w_link_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_sw     <= '0;
            r_bc     <= chs_pkg::BUCKET_COUNT_RST;
            r_free   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_bc <= i_cfg_data[CW-1:0];
            end
            // S_DONE owns the output valid while it is active
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    if (32'(r_sw) == SWN - 1) begin
                        r_state <= S_IDLE;
                    end
                    r_sw <= r_sw + XW'(1);
                end
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_op    <= s_axis_tuser;
                        r_key   <= s_axis_tdata[KW-1:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_bucket <= BW'(w_rem);
                        r_state  <= S_HEAD;
                    end
                end
                S_HEAD: r_state <= S_HEAD_WT;
                S_HEAD_WT: begin
                    r_cur   <= r_head_q;
                    r_headv <= r_head_q;
                    r_prev  <= NULL_LINK;
                    r_steps <= '0;
                    r_found <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_cur < NULL_LINK && r_steps < NW'(NODES)) begin
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_CMP: begin
                    if (r_key_q == r_key) begin
                        r_found <= 1'b1;
                        r_hit   <= r_cur;
                        r_next  <= r_link_q;
                        r_state <= S_DECIDE;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q;
                        r_steps <= r_steps + NW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_DECIDE: begin
                    r_state <= S_DONE;
                    case (r_op)
                        chs_pkg::OP_INSERT: begin
                            if (r_found) begin
                                r_stat <= chs_pkg::ST_DUPLICATE;
                            end else if (r_free >= NULL_LINK) begin
                                r_stat <= chs_pkg::ST_POOL_FULL;
                            end else begin
                                r_stat  <= chs_pkg::ST_INSERTED;
                                r_state <= S_INS_RD;
                            end
                        end
                        chs_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                r_stat  <= chs_pkg::ST_REMOVED;
                                r_state <= S_REM1;
                            end else begin
                                r_stat <= chs_pkg::ST_REM_MISS;
                            end
                        end
                        default: begin
                            r_stat <= r_found ? chs_pkg::ST_FOUND : chs_pkg::ST_ABSENT;
                        end
                    endcase
                end
                S_INS_RD: r_state <= S_INS_WR;
                S_INS_WR: begin
                    r_free  <= r_link_q;
                    r_count <= r_count + NW'(1);
                    r_state <= S_DONE;
                end
                S_REM1: r_state <= S_REM2;
                S_REM2: begin
                    r_free <= r_hit;
                    if (r_count != '0) begin
                        r_count <= r_count - NW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_res_stat <= r_stat;
                        r_total    <= TW'(r_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_total, r_res_stat};

endmodule

FILE: hdl/chs_checker.sv
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks for the chained hash set core.
// ----------------------------------------------------------------------------
module chs_checker #(
    parameter int NODES = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
        else $error("bad status code");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[11:3]) <= NODES)
        else $error("element count beyond pool");

    // one request in flight at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind chained_hash_set_core chs_checker #(.NODES(NODES)) u_chs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/chained_hash_set_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_core_test
// Feeds insert, remove and search requests to the hash set core, predicts
// each status and element count with its own chained table and free list,
// and checks every result transfer in order. Both streams idle at random.
// ----------------------------------------------------------------------------
module chained_hash_set_core_test;

    localparam int BUCKETS   = 64;
    localparam int NODES     = 256;
    localparam int NULL_LINK = NODES;
    localparam int LIMIT     = 4000000;
    localparam int SETTLE    = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [30:0] key
    logic [1:0]  s_axis_tuser;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [2:0] status, [11:3] element_total
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;      // [6:0] bucket_count

    chained_hash_set_core #(.BUCKETS(BUCKETS), .NODES(NODES)) DUT (.*);

    // predicted table contents
    logic [chs_pkg::CFG_W-1:0]   tbl_buckets;
    logic [8:0]                  tbl_head [BUCKETS];
    logic [chs_pkg::KEY_W-1:0]   tbl_key  [NODES];
    logic [8:0]                  tbl_link [NODES];
    logic [8:0]                  tbl_free;
    logic [chs_pkg::TOTAL_W-1:0] tbl_count;

    logic [chs_pkg::STAT_W-1:0]  want_status [$];
    logic [chs_pkg::TOTAL_W-1:0] want_total  [$];

    int errors;
    int cycles;
    int hold_off;
    bit stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report(string what, int got, int exp);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, exp, cycles);
        errors++;
    endtask

    function automatic void table_reset();
        tbl_buckets = chs_pkg::BUCKET_COUNT_RST;
        foreach (tbl_head[i]) tbl_head[i] = 9'(NULL_LINK);
        foreach (tbl_link[i]) begin
            tbl_link[i] = 9'(i + 1);
            tbl_key[i]  = '0;
        end
        tbl_free  = '0;
        tbl_count = '0;
    endfunction

    // applies one request to the predicted table and queues its result
    function automatic void table_apply(logic [chs_pkg::OP_W-1:0] op,
                                        logic [chs_pkg::KEY_W-1:0] key);
        int m, b, prev, cur, steps, hit, nxt;
        bit present;
        logic [chs_pkg::STAT_W-1:0] st;
        m = tbl_buckets;
        if (m == 0) m = 1;
        if (m > BUCKETS) m = BUCKETS;
        b = key % m;
        prev = NULL_LINK;
        hit = NULL_LINK;
        present = 0;
        cur = tbl_head[b];
        steps = 0;
        while (cur < NODES && steps < NODES && !present) begin
            if (tbl_key[cur] == key) begin
                present = 1;
                hit = cur;
            end else begin
                prev = cur;
                cur = tbl_link[cur];
                steps++;
            end
        end
        if (op == chs_pkg::OP_INSERT) begin
            if (present) st = chs_pkg::ST_DUPLICATE;
            else if (tbl_free >= NODES) st = chs_pkg::ST_POOL_FULL;
            else begin
                nxt = tbl_free;
                tbl_free = tbl_link[nxt];
                tbl_key[nxt] = key;
                tbl_link[nxt] = tbl_head[b];
                tbl_head[b] = 9'(nxt);
                tbl_count++;
                st = chs_pkg::ST_INSERTED;
            end
        end else if (op == chs_pkg::OP_REMOVE) begin
            if (present) begin
                nxt = tbl_link[hit];
                if (prev < NODES) tbl_link[prev] = 9'(nxt);
                else tbl_head[b] = 9'(nxt);
                tbl_link[hit] = tbl_free;
                tbl_free = 9'(hit);
                if (tbl_count > 0) tbl_count--;
                st = chs_pkg::ST_REMOVED;
            end else begin
                st = chs_pkg::ST_REM_MISS;
            end
        end else begin
            st = present ? chs_pkg::ST_FOUND : chs_pkg::ST_ABSENT;
        end
        want_status.push_back(st);
        want_total.push_back(tbl_count);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // called at a rising edge; returns at the edge where the request transfers
    task automatic send_request(logic [chs_pkg::OP_W-1:0] op,
                                logic [chs_pkg::KEY_W-1:0] key, bit gaps = 1);
        int gap;
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, key};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        table_apply(op, key);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (want_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_buckets(logic [chs_pkg::CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {1'b0, value};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tbl_buckets = value;
    endtask

    // receiver: random stalls, plus a requested long hold-off
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (stalls_on && $urandom_range(0, 9) == 0)
                    stall = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                        : $urandom_range(1, 4);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (want_status.size() == 0) begin
                report("unexpected result transfer", m_axis_tdata, 0);
            end else begin
                if (m_axis_tdata[2:0] != want_status[0])
                    report("status", m_axis_tdata[2:0], want_status[0]);
                if (m_axis_tdata[11:3] != want_total[0])
                    report("element_total", m_axis_tdata[11:3], want_total[0]);
                void'(want_status.pop_front());
                void'(want_total.pop_front());
            end
        end
    end

    task automatic test_basic_ops();
        send_request(chs_pkg::OP_INSERT, 31'd0);
        send_request(chs_pkg::OP_INSERT, 31'd0);             // duplicate
        send_request(chs_pkg::OP_INSERT, 31'h7FFF_FFFF);
        send_request(chs_pkg::OP_INSERT, 31'd64);            // same bucket as 0
        send_request(chs_pkg::OP_INSERT, 31'd128);
        send_request(chs_pkg::OP_SEARCH, 31'd64);
        send_request(chs_pkg::OP_SEARCH, 31'd0);
        send_request(chs_pkg::OP_SEARCH, 31'd5);
        send_request(2'd3, 31'd0);                           // op 3 acts as search
        send_request(2'd3, 31'h5555_5555);
        send_request(chs_pkg::OP_REMOVE, 31'd64);            // middle of chain
        send_request(chs_pkg::OP_REMOVE, 31'd64);            // miss
        send_request(chs_pkg::OP_REMOVE, 31'd128);           // chain head
        send_request(chs_pkg::OP_REMOVE, 31'h7FFF_FFFF);
        send_request(chs_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        send_request(chs_pkg::OP_REMOVE, 31'd0);
    endtask

    task automatic test_bucket_settings();
        set_buckets(7'd0);                                   // zero acts as one
        send_request(chs_pkg::OP_INSERT, 31'd3);
        send_request(chs_pkg::OP_INSERT, 31'd1000);
        send_request(chs_pkg::OP_SEARCH, 31'd3);
        set_buckets(7'd127);                                 // above the table size
        send_request(chs_pkg::OP_INSERT, 31'd200);
        send_request(chs_pkg::OP_SEARCH, 31'd3);             // stored under old modulus
        send_request(chs_pkg::OP_SEARCH, 31'd1000);
        set_buckets(7'd1);
        send_request(chs_pkg::OP_SEARCH, 31'd1000);
        send_request(chs_pkg::OP_REMOVE, 31'd3);
        set_buckets(7'd64);
    endtask

    // fill the pool, hit the full case, then empty it again
    task automatic test_pool_full();
        logic [chs_pkg::KEY_W-1:0] stored [$];
        logic [chs_pkg::KEY_W-1:0] k;
        set_buckets(7'd37);
        while (tbl_free < NODES) begin
            k = chs_pkg::KEY_W'($urandom_range(5000, 900000));
            stored.push_back(k);
            send_request(chs_pkg::OP_INSERT, k, 0);
        end
        send_request(chs_pkg::OP_INSERT, 31'd4242);           // pool full
        send_request(chs_pkg::OP_INSERT, stored[0]);          // duplicate while full
        // receiver holds off while requests keep coming
        hold_off = 600;
        repeat (6) send_request(chs_pkg::OP_SEARCH,
                                stored[$urandom_range(0, stored.size() - 1)], 0);
        foreach (stored[i]) send_request(chs_pkg::OP_REMOVE, stored[i]);
        set_buckets(7'd64);
    endtask

    task automatic test_random_traffic();
        logic [chs_pkg::CFG_W-1:0] setting;
        logic [chs_pkg::KEY_W-1:0] k;
        int r;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: setting = 7'd64;
                1: setting = 7'd1;
                2: setting = 7'd127;
                default: setting = 7'($urandom_range(0, 127));
            endcase
            set_buckets(setting);
            stalls_on = (phase != 3);
            for (int n = 0; n < 72; n++) begin
                r = $urandom_range(0, 99);
                if (r < 75) k = chs_pkg::KEY_W'($urandom_range(0, 300));
                else if (r < 90) k = chs_pkg::KEY_W'($urandom());
                else k = chs_pkg::KEY_W'(32'h7FFF_FFFF - $urandom_range(0, 3));
                send_request(2'($urandom_range(0, 3)), k, phase != 4);
            end
        end
        stalls_on = 1;
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        stalls_on = 1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_bucket_settings();
        test_pool_full();
        test_random_traffic();

        wait_drained();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
